// ===== rtl/mcse_pkg.sv =====
// shared types, constants and helper function for the modem clock string decoder
package mcse_pkg;

    // channel payloads
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [31:0] y2k_seconds;
        logic        date_ok;
    } t_out_item;

    // captured fields of one complete clock string
    typedef struct packed {
        logic [6:0] year;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [6:0] zone_q;
        logic       zone_neg;
    } t_fields;

    // character codes
    localparam logic [7:0] CharQuote = 8'h22;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    // time constants
    localparam logic [31:0] EpochOffset   = 32'd946684800;
    localparam logic [8:0]  DaysPerYear   = 9'd365;
    localparam logic [4:0]  HoursPerDay   = 5'd24;
    localparam logic [5:0]  SecPerMin     = 6'd60;
    localparam logic [9:0]  SecPerQuarter = 10'd900;
    localparam logic [6:0]  MonthMax      = 7'd12;
    localparam logic [6:0]  DayMax        = 7'd31;
    localparam logic [6:0]  LeapMonth     = 7'd3;

    // depth of the queue between parser and arithmetic
    localparam int QueueDepth = 2;

    // days in the year before the first of the given month (1..12)
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/mcse_front.sv =====
// character parser: tracks position, captures digit pairs, hands off finished strings
module mcse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mcse_pkg::t_in_item i_data,
    output logic               o_stall,
    input  logic               i_full,
    output logic               o_push,
    output mcse_pkg::t_fields  o_push_fields
);
    import mcse_pkg::*;

    // character positions after the optional quote
    localparam logic [4:0] PosYearT   = 5'd0;
    localparam logic [4:0] PosYearU   = 5'd1;
    localparam logic [4:0] PosMonthT  = 5'd3;
    localparam logic [4:0] PosMonthU  = 5'd4;
    localparam logic [4:0] PosDayT    = 5'd6;
    localparam logic [4:0] PosDayU    = 5'd7;
    localparam logic [4:0] PosHourT   = 5'd9;
    localparam logic [4:0] PosHourU   = 5'd10;
    localparam logic [4:0] PosMinT    = 5'd12;
    localparam logic [4:0] PosMinU    = 5'd13;
    localparam logic [4:0] PosSecT    = 5'd15;
    localparam logic [4:0] PosSecU    = 5'd16;
    localparam logic [4:0] PosSign    = 5'd17;
    localparam logic [4:0] PosZoneT   = 5'd18;
    localparam logic [4:0] PosZoneU   = 5'd19;
    localparam logic [4:0] PosMax     = 5'd31;

    logic [4:0] r_pos,    n_pos;
    logic       r_quote,  n_quote;
    t_fields    r_fields, n_fields;

    logic       accept;
    logic       is_digit;
    logic [7:0] char_off;
    logic [3:0] digit;
    logic [6:0] tens;
    logic [6:0] units;
    logic       is_quote;

    assign o_stall = i_full;
    assign accept  = i_valid && !o_stall;

    // digit value, non-digits count as zero
    assign is_digit = (i_data.char_code >= CharZero) && (i_data.char_code <= CharNine);
    assign char_off = i_data.char_code - CharZero;
    assign digit    = is_digit ? char_off[3:0] : 4'd0;
    assign tens     = {digit, 3'b000} + 7'({digit, 1'b0});
    assign units    = 7'(digit);
    assign is_quote = (r_pos == PosYearT) && !r_quote && (i_data.char_code == CharQuote);

    // next capture state
    always_comb begin
        n_fields = r_fields;
        n_pos    = r_pos;
        n_quote  = r_quote;
        if (is_quote) begin
            n_quote = 1'b1;
        end else begin
            unique case (r_pos)
                PosYearT:  n_fields.year     = tens;
                PosYearU:  n_fields.year     = r_fields.year + units;
                PosMonthT: n_fields.month    = tens;
                PosMonthU: n_fields.month    = r_fields.month + units;
                PosDayT:   n_fields.day      = tens;
                PosDayU:   n_fields.day      = r_fields.day + units;
                PosHourT:  n_fields.hour     = tens;
                PosHourU:  n_fields.hour     = r_fields.hour + units;
                PosMinT:   n_fields.minute   = tens;
                PosMinU:   n_fields.minute   = r_fields.minute + units;
                PosSecT:   n_fields.second   = tens;
                PosSecU:   n_fields.second   = r_fields.second + units;
                PosSign:   n_fields.zone_neg = (i_data.char_code == CharMinus);
                PosZoneT:  n_fields.zone_q   = tens;
                PosZoneU:  n_fields.zone_q   = r_fields.zone_q + units;
                default:   ;
            endcase
            if (r_pos != PosMax) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    // capture registers, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_quote  <= 1'b0;
            r_fields <= '0;
        end else if (accept) begin
            if (i_data.last_char) begin
                r_pos    <= '0;
                r_quote  <= 1'b0;
                r_fields <= '0;
            end else begin
                r_pos    <= n_pos;
                r_quote  <= n_quote;
                r_fields <= n_fields;
            end
        end
    end

    // hand off the finished string including its last character
    assign o_push        = accept && i_data.last_char;
    assign o_push_fields = n_fields;

endmodule

// ===== rtl/mcse_queue.sv =====
// small first-in first-out buffer of captured field sets
module mcse_queue #(
    parameter int DEPTH = mcse_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mcse_pkg::t_fields i_push_fields,
    output logic              o_full,
    output logic              o_valid,
    output mcse_pkg::t_fields o_fields,
    input  logic              i_pop
);
    import mcse_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_fields         r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full   = (r_count == CntFull);
    assign o_valid  = (r_count != '0);
    assign o_fields = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_fields;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

// ===== rtl/mcse_back.sv =====
// arithmetic pipeline: day count, hours, minutes, seconds, zone and epoch offsets
module mcse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mcse_pkg::t_fields  i_fields,
    output logic               o_pop,
    output logic               o_valid,
    output mcse_pkg::t_out_item o_data,
    input  logic               i_stall
);
    import mcse_pkg::*;

    logic        advance;

    // stage 1: day count and zone seconds
    logic        r_s1_valid, r_s1_ok, r_s1_neg;
    logic [15:0] r_s1_days;
    logic [6:0]  r_s1_hour, r_s1_min, r_s1_sec;
    logic [16:0] r_s1_zone;
    // stage 2: hours
    logic        r_s2_valid, r_s2_ok, r_s2_neg;
    logic [19:0] r_s2_hours;
    logic [6:0]  r_s2_min, r_s2_sec;
    logic [16:0] r_s2_zone;
    // stage 3: minutes
    logic        r_s3_valid, r_s3_ok, r_s3_neg;
    logic [25:0] r_s3_mins;
    logic [6:0]  r_s3_sec;
    logic [16:0] r_s3_zone;
    // stage 4: local seconds and offsets
    logic        r_s4_valid, r_s4_ok;
    logic [31:0] r_s4_secs;
    logic [31:0] r_s4_adj_y2k;
    logic [31:0] r_s4_adj_unix;
    // output register
    logic        r_out_valid;
    t_out_item   r_out;

    logic        date_ok;
    logic        leap;
    logic [15:0] year16;
    logic [15:0] n_days;
    logic [16:0] n_zone;
    logic [31:0] zone32;

    // whole pipeline moves unless a finished result is held by the receiver
    assign advance = !(r_out_valid && i_stall);
    assign o_pop   = i_valid && advance;

    // date check and day count
    assign date_ok = (i_fields.month >= 7'd1) && (i_fields.month <= MonthMax) &&
                     (i_fields.day >= 7'd1) && (i_fields.day <= DayMax);
    assign leap    = (i_fields.month >= LeapMonth) && (i_fields.year[1:0] == 2'b00);
    assign year16  = 16'(i_fields.year);
    assign n_days  = (16'(i_fields.day) - 16'd1) + year16 * 16'(DaysPerYear)
                   + ((year16 + 16'd3) >> 2) + 16'(cum_days(i_fields.month[3:0]))
                   + 16'(leap);
    assign n_zone  = 17'(i_fields.zone_q) * 17'(SecPerQuarter);
    assign zone32  = 32'(r_s3_zone);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ok   <= date_ok;
            r_s1_neg  <= i_fields.zone_neg;
            r_s1_days <= n_days;
            r_s1_hour <= i_fields.hour;
            r_s1_min  <= i_fields.minute;
            r_s1_sec  <= i_fields.second;
            r_s1_zone <= n_zone;

            r_s2_ok    <= r_s1_ok;
            r_s2_neg   <= r_s1_neg;
            r_s2_hours <= 20'(r_s1_days) * 20'(HoursPerDay) + 20'(r_s1_hour);
            r_s2_min   <= r_s1_min;
            r_s2_sec   <= r_s1_sec;
            r_s2_zone  <= r_s1_zone;

            r_s3_ok   <= r_s2_ok;
            r_s3_neg  <= r_s2_neg;
            r_s3_mins <= 26'(r_s2_hours) * 26'(SecPerMin) + 26'(r_s2_min);
            r_s3_sec  <= r_s2_sec;
            r_s3_zone <= r_s2_zone;

            r_s4_ok       <= r_s3_ok;
            r_s4_secs     <= 32'(r_s3_mins) * 32'(SecPerMin) + 32'(r_s3_sec);
            r_s4_adj_y2k  <= r_s3_neg ? zone32 : 32'd0 - zone32;
            r_s4_adj_unix <= r_s3_neg ? EpochOffset + zone32 : EpochOffset - zone32;

            r_out.date_ok      <= r_s4_ok;
            r_out.y2k_seconds  <= r_s4_ok ? r_s4_secs + r_s4_adj_y2k : 32'd0;
            r_out.unix_seconds <= r_s4_ok ? r_s4_secs + r_s4_adj_unix : 32'd0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/modem_clock_string_to_epoch.sv =====
// top level: modem clock string to epoch seconds converter
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one character of a
// clock string "yy/MM/dd,hh:mm:ss+zz" per transfer, an optional leading quote
// first; last_char marks the final character of a string.
// Output channel (o_out_valid / i_out_stall / o_out_data) gives one transfer per
// string: seconds since 1970 and since 2000-01-01 in UTC, and date_ok.
// Throughput: one character per cycle while o_in_stall is low, set by the parser front.
// After the transfer of the last character the captured string passes the queue,
// four arithmetic stages (day count and zone, hours, minutes, seconds and
// offsets) and the output register.
// A queue of QUEUE_DEPTH captured strings sits between parser and arithmetic.
// When the receiver stalls, the arithmetic pipeline holds; the parser keeps
// taking characters and raises o_in_stall only while the queue is full.
// Reset (synchronous, active low) clears the parser position, all captured
// fields, the queue and every pipeline valid bit; no result is pending.
module modem_clock_string_to_epoch #(
    parameter int QUEUE_DEPTH = mcse_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mcse_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mcse_pkg::t_out_item  o_out_data
);
    import mcse_pkg::*;

    logic    q_full;
    logic    q_push;
    t_fields q_push_fields;
    logic    q_valid;
    t_fields q_fields;
    logic    q_pop;

    // parser front
    mcse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_data        (i_in_data),
        .o_stall       (o_in_stall),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_push_fields (q_push_fields)
    );

    // queue between front and back
    mcse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (q_push),
        .i_push_fields (q_push_fields),
        .o_full        (q_full),
        .o_valid       (q_valid),
        .o_fields      (q_fields),
        .i_pop         (q_pop)
    );

    // arithmetic back
    mcse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_fields (q_fields),
        .o_pop    (q_pop),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .i_stall  (i_out_stall)
    );

`ifndef SYNTHESIS
    // the parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("queue push while full");

    // a rejected date carries zero seconds
    a_bad_date_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.date_ok) |->
        (o_out_data.unix_seconds == 32'd0 && o_out_data.y2k_seconds == 32'd0))
        else $error("bad date with nonzero seconds");

    // both results differ by the 1970 to 2000 offset
    a_epoch_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.date_ok) |->
        (o_out_data.unix_seconds == o_out_data.y2k_seconds + EpochOffset))
        else $error("epoch offset mismatch");

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule
